/* src/srtp_pkg.sv */
// Shared types, constants and pattern tables of the SRT timestamp line parser.
package srtp_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [POS_W-1:0] POS_FIRST     = 5'd0;
  localparam logic [POS_W-1:0] POS_END_FIRST = 5'd7;
  localparam logic [POS_W-1:0] POS_LAST_NUM  = 5'd18;
  localparam logic [POS_W-1:0] POS_DONE      = 5'd19;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NONE  = 8'h00;

  localparam logic [31:0] MULT_MIN = 32'd60;
  localparam logic [31:0] MULT_MS  = 32'd1000;
  localparam logic [31:0] MULT_DEC = 32'd10;

  typedef enum logic [1:0] {
    EK_NUM,
    EK_LIT,
    EK_WS
  } elem_kind_t;

  typedef struct packed {
    logic               matched;
    logic signed [31:0] start_ms;
    logic signed [31:0] end_ms;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             mismatch;
  } status_t;

  function automatic elem_kind_t elem_kind(input logic [POS_W-1:0] pos);
    elem_kind_t k;
    case (pos) inside
      5'd1, 5'd3, 5'd5, 5'd8, 5'd9, 5'd10, 5'd13, 5'd15, 5'd17: k = EK_LIT;
      5'd7, 5'd11:                                              k = EK_WS;
      default:                                                  k = EK_NUM;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] elem_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos) inside
      5'd1, 5'd3, 5'd13, 5'd15: c = CH_COLON;
      5'd5, 5'd17:              c = CH_COMMA;
      5'd8, 5'd9:               c = CH_DASH;
      5'd10:                    c = CH_GT;
      default:                  c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] elem_mult(input logic [POS_W-1:0] pos);
    return (pos == 5'd6 || pos == POS_LAST_NUM) ? MULT_MS : MULT_MIN;
  endfunction

endpackage

/* src/srtp_in_if.sv */
// Byte input channel of the SRT timestamp line parser.
interface srtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink   (input valid, input ch, input line_last, output ready);
endinterface

/* src/srtp_out_if.sv */
// Result channel of the SRT timestamp line parser.
interface srtp_out_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic signed [31:0] start_ms;
  logic signed [31:0] end_ms;

  modport source (output valid, output matched, output start_ms, output end_ms, input ready);
  modport sink   (input valid, input matched, input start_ms, input end_ms, output ready);
endinterface

/* src/srtp_core.sv */
// Pattern matcher state and per-byte register update of the SRT timestamp line parser.
module srtp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        ch,
  input  logic              line_last,
  output srtp_pkg::result_t res,
  output srtp_pkg::status_t stat
);
  import srtp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             neg_r, neg_nxt;
  logic             dig_r, dig_nxt;
  logic             sgn_r, sgn_nxt;
  logic [31:0]      st_r, st_nxt;
  logic [31:0]      et_r, et_nxt;
  logic             mis_r, mis_nxt;

  logic       go;
  logic       is_sp;
  logic       is_sgn;
  logic       is_dig;
  logic       is_minus;
  logic       ok;
  logic [31:0] dval;

  function automatic logic [31:0] fold(input logic [31:0] total, input logic [31:0] mag,
                                       input logic neg, input logic [POS_W-1:0] pos);
    logic [31:0] v;
    v = neg ? (32'd0 - mag) : mag;
    return total * elem_mult(pos) + v;
  endfunction

  assign is_sp    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_minus = (ch == CH_DASH);
  assign is_sgn   = (ch == CH_PLUS) || is_minus;
  assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval     = {28'd0, ch[3:0]};

  always_comb begin
    pos_nxt = pos_r;
    val_nxt = val_r;
    neg_nxt = neg_r;
    dig_nxt = dig_r;
    sgn_nxt = sgn_r;
    st_nxt  = st_r;
    et_nxt  = et_r;
    mis_nxt = mis_r;
    go      = !mis_r && (pos_r < POS_DONE);

    // number element with its running state
    if (go && elem_kind(pos_nxt) == EK_NUM) begin
      if (is_sp && !dig_nxt && !sgn_nxt) begin
        go = 1'b0;
      end else if (is_sgn && !dig_nxt && !sgn_nxt) begin
        sgn_nxt = 1'b1;
        neg_nxt = is_minus;
        go      = 1'b0;
      end else if (is_dig) begin
        val_nxt = val_nxt * MULT_DEC + dval;
        dig_nxt = 1'b1;
        go      = 1'b0;
      end else if (!dig_nxt) begin
        mis_nxt = 1'b1;
        go      = 1'b0;
      end else begin
        if (pos_nxt < POS_END_FIRST) begin
          st_nxt = fold(st_nxt, val_nxt, neg_nxt, pos_nxt);
        end else begin
          et_nxt = fold(et_nxt, val_nxt, neg_nxt, pos_nxt);
        end
        val_nxt = 32'd0;
        neg_nxt = 1'b0;
        dig_nxt = 1'b0;
        sgn_nxt = 1'b0;
        pos_nxt = pos_nxt + 5'd1;
      end
    end

    // whitespace run
    if (go && pos_nxt < POS_DONE && elem_kind(pos_nxt) == EK_WS) begin
      if (is_sp) begin
        go = 1'b0;
      end else begin
        pos_nxt = pos_nxt + 5'd1;
      end
    end

    // literal
    if (go && pos_nxt < POS_DONE && elem_kind(pos_nxt) == EK_LIT) begin
      if (ch == elem_char(pos_nxt)) begin
        pos_nxt = pos_nxt + 5'd1;
      end else begin
        mis_nxt = 1'b1;
      end
      go = 1'b0;
    end

    // fresh number reached past a whitespace run
    if (go && pos_nxt < POS_DONE && elem_kind(pos_nxt) == EK_NUM) begin
      if (is_sgn) begin
        sgn_nxt = 1'b1;
        neg_nxt = is_minus;
      end else if (is_dig) begin
        val_nxt = dval;
        dig_nxt = 1'b1;
      end else begin
        mis_nxt = 1'b1;
      end
    end

    // close the last number at line end
    if (line_last && !mis_nxt && pos_nxt == POS_LAST_NUM && dig_nxt) begin
      et_nxt  = fold(et_nxt, val_nxt, neg_nxt, pos_nxt);
      pos_nxt = POS_DONE;
    end

    ok           = !mis_nxt && (pos_nxt == POS_DONE);
    res.matched  = ok;
    res.start_ms = ok ? $signed(st_nxt) : 32'sd0;
    res.end_ms   = ok ? $signed(et_nxt) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && line_last)) begin
      pos_r <= POS_FIRST;
      val_r <= 32'd0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
      sgn_r <= 1'b0;
      st_r  <= 32'd0;
      et_r  <= 32'd0;
      mis_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_nxt;
      val_r <= val_nxt;
      neg_r <= neg_nxt;
      dig_r <= dig_nxt;
      sgn_r <= sgn_nxt;
      st_r  <= st_nxt;
      et_r  <= et_nxt;
      mis_r <= mis_nxt;
    end
  end

  assign stat.pos      = pos_r;
  assign stat.mismatch = mis_r;

endmodule

/* src/srt_timestamp_line_parser.sv */
// Top level of the SRT timestamp line parser: byte intake, matcher and result register.
// Streams one text line a byte per beat and matches "H:M:S,ms --> H:M:S,ms" with
// scanf-style number rules (leading whitespace, optional sign, wrapping magnitude).
// The matcher state advances in a single register update per accepted beat, so a new
// byte is taken on every clock while the result register is empty or being drained.
// On the beat that carries line_last, one result appears on the output channel in the
// next cycle with the match flag and both times in milliseconds (zero times when the
// line does not match). Bytes after the eighth number are ignored.
module srt_timestamp_line_parser (
  input  logic            clk,
  input  logic            rst_n,
  srtp_in_if.sink         in_bus,
  srtp_out_if.source      out_bus
);
  import srtp_pkg::*;

  logic    accept;
  logic    out_valid_r;
  result_t res;
  result_t res_r;
  status_t stat;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  srtp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (accept),
    .ch        (in_bus.ch),
    .line_last (in_bus.line_last),
    .res       (res),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_bus.line_last) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_bus.line_last) begin
      res_r <= res;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.matched  = res_r.matched;
  assign out_bus.start_ms = res_r.start_ms;
  assign out_bus.end_ms   = res_r.end_ms;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_bus.line_last |=> out_valid_r)
    else $error("line end beat did not load a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && in_bus.line_last))
    else $error("result appeared without a line end beat");

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_bus.line_last |=> stat.pos == POS_FIRST && !stat.mismatch)
    else $error("matcher did not return to line start");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.matched |-> res_r.start_ms == 32'sd0 && res_r.end_ms == 32'sd0)
    else $error("unmatched result carries nonzero times");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the SRT timestamp line parser: directed and random text lines.
module testbench;
  import srtp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [POS_W-1:0] POS_FIRST_MS = 5'd6;

  logic clk;
  logic rst_n;

  srtp_in_if  in_bus ();
  srtp_out_if out_bus ();

  srt_timestamp_line_parser uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  logic [POS_W-1:0] scan_pos;
  logic [31:0]      num_mag;
  logic             num_neg;
  logic             num_has_digit;
  logic             num_has_sign;
  logic [31:0]      start_acc;
  logic [31:0]      end_acc;
  logic             line_bad;

  result_t     expected_cues [$];
  result_t     cue_want;
  logic [7:0]  line_buf [$];
  int unsigned fail_count;
  int unsigned beats_taken;
  int unsigned cycles = 0;
  logic        steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_bus.ready <= steady || ($urandom_range(99) >= 38);
  end

  function automatic elem_kind_t kind_at(input logic [POS_W-1:0] p);
    case (p)
      5'd1, 5'd3, 5'd5, 5'd8, 5'd9, 5'd10, 5'd13, 5'd15, 5'd17: return EK_LIT;
      5'd7, 5'd11: return EK_WS;
      default: return EK_NUM;
    endcase
  endfunction

  function void clear_line_state();
    scan_pos      = POS_FIRST;
    num_mag       = '0;
    num_neg       = 1'b0;
    num_has_digit = 1'b0;
    num_has_sign  = 1'b0;
    start_acc     = '0;
    end_acc       = '0;
    line_bad      = 1'b0;
  endfunction

  function void fold_number();
    logic [31:0] v;
    logic [31:0] mult;
    v = num_neg ? (32'd0 - num_mag) : num_mag;
    mult = (scan_pos == POS_FIRST_MS || scan_pos == POS_LAST_NUM) ? MULT_MS : MULT_MIN;
    if (scan_pos < POS_END_FIRST) start_acc = start_acc * mult + v;
    else end_acc = end_acc * mult + v;
    num_mag       = '0;
    num_neg       = 1'b0;
    num_has_digit = 1'b0;
    num_has_sign  = 1'b0;
    scan_pos      = scan_pos + 1'b1;
  endfunction

  function void track_beat(input logic [7:0] c, input logic last);
    logic    again;
    logic    is_ws;
    logic    is_digit;
    logic    ok;
    logic [7:0] lit;
    result_t cue;
    is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    again    = 1'b1;
    while (again && !line_bad && scan_pos < POS_DONE) begin
      again = 1'b0;
      case (kind_at(scan_pos))
        EK_NUM: begin
          if (!num_has_digit && !num_has_sign && (is_ws || c == CH_PLUS || c == CH_DASH)) begin
            if (!is_ws) begin
              num_has_sign = 1'b1;
              num_neg      = (c == CH_DASH);
            end
          end else if (is_digit) begin
            num_mag       = num_mag * MULT_DEC + 32'(c - CH_ZERO);
            num_has_digit = 1'b1;
          end else if (!num_has_digit) begin
            line_bad = 1'b1;
          end else begin
            fold_number();
            again = 1'b1;
          end
        end
        EK_LIT: begin
          case (scan_pos)
            5'd1, 5'd3, 5'd13, 5'd15: lit = CH_COLON;
            5'd5, 5'd17:              lit = CH_COMMA;
            5'd10:                    lit = CH_GT;
            default:                  lit = CH_DASH;
          endcase
          if (c == lit) scan_pos = scan_pos + 1'b1;
          else line_bad = 1'b1;
        end
        default: begin
          if (!is_ws) begin
            scan_pos = scan_pos + 1'b1;
            again    = 1'b1;
          end
        end
      endcase
    end
    if (last) begin
      if (!line_bad && scan_pos == POS_LAST_NUM && num_has_digit) fold_number();
      ok           = !line_bad && scan_pos == POS_DONE;
      cue.matched  = ok;
      cue.start_ms = ok ? start_acc : 32'sd0;
      cue.end_ms   = ok ? end_acc : 32'sd0;
      expected_cues.push_back(cue);
      clear_line_state();
    end
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_cues.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got matched=%0d start=%0d end=%0d",
                 $time, out_bus.matched, out_bus.start_ms, out_bus.end_ms);
      end else begin
        cue_want = expected_cues.pop_front();
        if (out_bus.matched !== cue_want.matched) begin
          fail_count++;
          $display("%0t: matched expected %0d, got %0d", $time, cue_want.matched,
                   out_bus.matched);
        end
        if (out_bus.start_ms !== cue_want.start_ms) begin
          fail_count++;
          $display("%0t: start_ms expected %0d, got %0d", $time, cue_want.start_ms,
                   out_bus.start_ms);
        end
        if (out_bus.end_ms !== cue_want.end_ms) begin
          fail_count++;
          $display("%0t: end_ms expected %0d, got %0d", $time, cue_want.end_ms,
                   out_bus.end_ms);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!steady && $urandom_range(99) < 38) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.ch        <= c;
    in_bus.line_last <= last;
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
    beats_taken++;
    track_beat(c, last);
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic load_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    load_text(s);
    send_line();
  endtask

  task automatic drain_cues();
    in_bus.valid <= 1'b0;
    while (expected_cues.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] ws_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  task automatic add_ws_run();
    repeat ($urandom_range(2)) line_buf.push_back(ws_char());
  endtask

  task automatic add_number();
    int unsigned digits;
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(ws_char());
    if ($urandom_range(4) == 0) line_buf.push_back($urandom_range(1) ? CH_PLUS : CH_DASH);
    digits = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    repeat (digits) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic build_cue_line();
    add_number();
    line_buf.push_back(CH_COLON);
    add_number();
    line_buf.push_back(CH_COLON);
    add_number();
    line_buf.push_back(CH_COMMA);
    add_number();
    add_ws_run();
    line_buf.push_back(CH_DASH);
    line_buf.push_back(CH_DASH);
    line_buf.push_back(CH_GT);
    add_ws_run();
    add_number();
    line_buf.push_back(CH_COLON);
    add_number();
    line_buf.push_back(CH_COLON);
    add_number();
    line_buf.push_back(CH_COMMA);
    add_number();
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 5))
      line_buf.push_back(8'($urandom_range(32, 126)));
  endtask

  task automatic test_well_formed();
    send_text("00:00:01,000 --> 00:00:04,074");
    send_text("99:59:59,999 --> 99:59:59,999");
    send_text("1:2:3,4-->5:6:7,8 trailing text");
    send_text("10:20:30,400 --> 11:21:31,500 99");
    load_text("1:2:3,4 --> 5:6:7,8");
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_number_rules();
    send_text("4294967295:4294967295:4294967295,4294967295 --> 99999999999:0:0,4294967296");
    send_text(" \011-1:+2:-3,+4\011-->\012\013\014\015-5:6:7,-8");
    send_text("-2147483648:0:0,0 --> +2147483647:0:0,0");
    send_text("  007:  08:\01509,\011010   -->0:0:0,0");
  endtask

  task automatic test_mismatches();
    send_text("-:2:3,4 --> 5:6:7,8");
    send_text("+-1:2:3,4 --> 5:6:7,8");
    send_text("- 1:2:3,4 --> 5:6:7,8");
    send_text("1:2:3.4 --> 5:6:7,8");
    send_text("1:2:3,4 -> 5:6:7,8");
    send_text("1 :2:3,4 --> 5:6:7,8");
    load_text("1:2");
    line_buf.push_back(CH_NONE);
    load_text(":3,4 --> 5:6:7,8");
    send_line();
    line_buf.push_back(8'hFF);
    load_text("1:2:3,4 --> 5:6:7,8");
    send_line();
    load_text("1:2:3,4 --> 5:6:");
    line_buf.push_back(8'h80);
    load_text("7,8");
    send_line();
  endtask

  task automatic test_line_ends();
    send_text("12:34:56,789 --> 12:34");
    send_text("1:2:3,4 --> 5:6:7,");
    send_text("1:2:3,4 --> 5:6:7,-");
    load_text("1:2:3,4 --> 5:6:7,8");
    line_buf.push_back(CH_NONE);
    load_text("9");
    send_line();
    send_text("7");
    line_buf.push_back(CH_NONE);
    send_line();
  endtask

  task automatic test_drain_between_lines();
    send_text("01:02:03,004 --> 05:06:07,008");
    drain_cues();
    @(posedge clk);
    send_text("02:00:00,000 --> 03:00:00,000");
  endtask

  task automatic test_random_lines();
    int unsigned first_beat;
    int unsigned lines_done;
    int unsigned pick;
    int unsigned keep;
    first_beat = beats_taken;
    lines_done = 0;
    while (beats_taken - first_beat < 180 || lines_done < 8) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        build_cue_line();
        if (pick >= 70) begin
          if ($urandom_range(1)) begin
            line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
          end else begin
            keep = $urandom_range(1, line_buf.size());
            while (line_buf.size() > keep) line_buf.delete(line_buf.size() - 1);
          end
        end
      end else begin
        repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
      end
      send_line();
      lines_done++;
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (3) begin
      build_cue_line();
      send_line();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.ch        <= '0;
    in_bus.line_last <= 1'b0;
    fail_count  = 0;
    beats_taken = 0;
    steady      = 1'b0;
    clear_line_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_well_formed();
    test_number_rules();
    test_mismatches();
    test_line_ends();
    test_drain_between_lines();
    test_random_lines();
    test_steady_stream();

    drain_cues();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
